// File: hdl/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types, constants and the microcode program of the switch sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  // Field widths
  localparam int unsigned NUM_W    = 6;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned VER_W    = 2;
  localparam int unsigned REP_W    = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned PC_W     = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT     = 2'd1;

  // Protocol constants
  localparam logic [VER_W-1:0]  MAX_VERSION    = 2'd1;
  localparam logic [REP_W-1:0]  MAX_REPEATS    = 4'd14;
  localparam logic [BYTE_W-1:0] FRAME_FIRST    = 8'hE0;
  localparam logic [BYTE_W-1:0] FRAME_REPEAT   = 8'hE1;
  localparam logic [BYTE_W-1:0] SWITCH_ADDR    = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_COMMITTED  = 8'h38;
  localparam logic [BYTE_W-1:0] CMD_UNCOMMITTED = 8'h39;
  localparam logic [3:0]        DATA_HIGH      = 4'hF;
  localparam logic [BYTE_W-1:0] SHORT_WAIT_MS  = 8'd15;
  localparam logic [BYTE_W-1:0] REPEAT_WAIT_MS = 8'd25;
  localparam logic [LEN_W-1:0]  MSG_LEN        = 3'd4;

  typedef enum logic [ACT_W-1:0] {
    ACT_TONE  = 3'd0,
    ACT_VOLT  = 3'd1,
    ACT_WAIT  = 3'd2,
    ACT_MSG   = 3'd3,
    ACT_BURST = 3'd4,
    ACT_ERROR = 3'd5
  } action_t;

  // Source of the action value
  typedef enum logic [2:0] {
    VAL_ZERO,
    VAL_POL,
    VAL_SHORT,
    VAL_REPEAT,
    VAL_BURST,
    VAL_BAND
  } val_sel_t;

  // Jump condition
  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_REPS_NZ,
    JMP_LOOP_MORE
  } jump_t;

  typedef struct packed {
    action_t          act;
    val_sel_t         val_sel;
    logic             frame_rep;   // E1 framing
    logic             cmd_unc;     // uncommitted command and port nibble
    jump_t            jmp;
    logic [PC_W-1:0]  target;
    logic             load_cnt;
    logic             dec_cnt;
    logic             last;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic   start;   // request transfer, latch operands
    logic   step;    // emit one result from word
    ucode_t word;
  } dsc_ctrl_t;

  localparam logic [PC_W-1:0] PC_START = 4'd0;
  localparam logic [PC_W-1:0] PC_ERROR = 4'd15;

  function automatic ucode_t mk(action_t act, val_sel_t vs, logic fr, logic unc,
                                jump_t jmp, logic [PC_W-1:0] tgt,
                                logic ld, logic dec, logic last);
    ucode_t w;
    w.act = act; w.val_sel = vs; w.frame_rep = fr; w.cmd_unc = unc;
    w.jmp = jmp; w.target = tgt; w.load_cnt = ld; w.dec_cnt = dec; w.last = last;
    return w;
  endfunction

  // Microcode program: one result per step
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:  w = mk(ACT_TONE,  VAL_ZERO,   1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd1:  w = mk(ACT_VOLT,  VAL_POL,    1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd2:  w = mk(ACT_WAIT,  VAL_SHORT,  1'b0, 1'b0, JMP_REPS_NZ,   4'd6,  1'b0, 1'b0, 1'b0);
      // no repeats: uncommitted, wait, committed
      4'd3:  w = mk(ACT_MSG,   VAL_ZERO,   1'b0, 1'b1, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd4:  w = mk(ACT_WAIT,  VAL_SHORT,  1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd5:  w = mk(ACT_MSG,   VAL_ZERO,   1'b0, 1'b0, JMP_ALWAYS,    4'd11, 1'b0, 1'b0, 1'b0);
      // committed first, then repeat pairs
      4'd6:  w = mk(ACT_MSG,   VAL_ZERO,   1'b0, 1'b0, JMP_NONE,      4'd0,  1'b1, 1'b0, 1'b0);
      4'd7:  w = mk(ACT_WAIT,  VAL_REPEAT, 1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd8:  w = mk(ACT_MSG,   VAL_ZERO,   1'b0, 1'b1, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd9:  w = mk(ACT_WAIT,  VAL_REPEAT, 1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd10: w = mk(ACT_MSG,   VAL_ZERO,   1'b1, 1'b0, JMP_LOOP_MORE, 4'd7,  1'b0, 1'b1, 1'b0);
      // tail: wait, burst, wait, final tone
      4'd11: w = mk(ACT_WAIT,  VAL_SHORT,  1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd12: w = mk(ACT_BURST, VAL_BURST,  1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd13: w = mk(ACT_WAIT,  VAL_SHORT,  1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b0);
      4'd14: w = mk(ACT_TONE,  VAL_BAND,   1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b1);
      4'd15: w = mk(ACT_ERROR, VAL_ZERO,   1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b1);
      default: w = mk(ACT_ERROR, VAL_ZERO, 1'b0, 1'b0, JMP_NONE,      4'd0,  1'b0, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/dsc_if.sv
// ----------------------------------------------------------------------------
// dsc_req_if / dsc_res_if
// Valid/ready channels for switch requests and sequencer actions.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsc_req_if;
  logic                      valid;
  logic                      ready;
  logic [dsc_pkg::NUM_W-1:0] input_number;
  logic                      polarization;
  logic                      band_select;

  modport source (output valid, input ready, output input_number, polarization, band_select);
  modport sink   (input valid, output ready, input input_number, polarization, band_select);
endinterface

interface dsc_res_if;
  logic                       valid;
  logic                       ready;
  logic [dsc_pkg::ACT_W-1:0]  action;
  logic [dsc_pkg::BYTE_W-1:0] action_value;
  logic [dsc_pkg::BYTE_W-1:0] frame_byte;
  logic [dsc_pkg::BYTE_W-1:0] device_address;
  logic [dsc_pkg::BYTE_W-1:0] command_byte;
  logic [dsc_pkg::BYTE_W-1:0] data_byte;
  logic [dsc_pkg::LEN_W-1:0]  message_length;
  logic                       last_action;

  modport source (output valid, input ready, output action, action_value, frame_byte,
                  device_address, command_byte, data_byte, message_length, last_action);
  modport sink   (input valid, output ready, input action, action_value, frame_byte,
                  device_address, command_byte, data_byte, message_length, last_action);
endinterface

`default_nettype wire

// File: hdl/diseqc_switch_command_sequencer.sv
// ----------------------------------------------------------------------------
// diseqc_switch_command_sequencer
// Turns one switch request into the ordered action list of a DiSEqC master.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  req     | in  | input_number, polarization, band_select          | valid/ready
//  res     | out | action, action_value, frame/address/cmd/data,    | valid/ready
//          |     | message_length, last_action                       |
//  cfg     | in  | cfg_index, cfg_data                               | cfg_we only
//
// One action leaves per cycle while the output register is free: 10 actions
// with no repeats, 8 + 4 * repeats otherwise, 1 for an unsupported version.
// The microcode step counter sets this; a new request is taken the cycle
// after the last action is loaded. A stalled output holds the step counter.
// Reset clears the configuration registers, the sequencer and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module diseqc_switch_command_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [dsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  dsc_req_if.sink                               req,
  dsc_res_if.source                             res
);
  import dsc_pkg::*;

  logic [VER_W-1:0] protocol_version;
  logic [REP_W-1:0] repeat_count;
  logic             room;
  logic             ready;
  dsc_ctrl_t        ctrl;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= '0;
      repeat_count     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROTOCOL_VERSION: protocol_version <= cfg_data[VER_W-1:0];
        CFG_REPEAT_COUNT:     repeat_count     <= cfg_data[REP_W-1:0];
        default: ;
      endcase
    end
  end

  assign req.ready = ready;

  dsc_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req.valid),
    .req_ready        (ready),
    .room             (room),
    .protocol_version (protocol_version),
    .repeat_count     (repeat_count),
    .ctrl             (ctrl)
  );

  dsc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .input_number (req.input_number),
    .polarization (req.polarization),
    .band_select  (req.band_select),
    .room         (room),
    .res          (res)
  );

endmodule

`default_nettype wire

// File: hdl/dsc_seq.sv
// ----------------------------------------------------------------------------
// dsc_seq
// Step counter, repeat counter and jump logic over the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output      logic                        req_ready,
  input  wire logic                        room,
  input  wire logic [dsc_pkg::VER_W-1:0]   protocol_version,
  input  wire logic [dsc_pkg::REP_W-1:0]   repeat_count,
  output      dsc_pkg::dsc_ctrl_t          ctrl
);
  import dsc_pkg::*;

  logic            busy;
  logic [PC_W-1:0] pc;
  logic [REP_W-1:0] cnt;
  logic [REP_W-1:0] reps;
  ucode_t          word;
  logic            start;
  logic            step;
  logic            taken;

  // Saturate the repeat count
  assign reps = (repeat_count > MAX_REPEATS) ? MAX_REPEATS : repeat_count;

  assign word      = ucode_rom(pc);
  assign req_ready = !busy && !rst;
  assign start     = req_valid && req_ready;
  assign step      = busy && room;

  // Evaluate the jump condition
  always_comb begin
    unique case (word.jmp)
      JMP_NONE:      taken = 1'b0;
      JMP_ALWAYS:    taken = 1'b1;
      JMP_REPS_NZ:   taken = (reps != '0);
      JMP_LOOP_MORE: taken = (cnt != REP_W'(1));
      default:       taken = 1'b0;
    endcase
  end

  assign ctrl.start = start;
  assign ctrl.step  = step;
  assign ctrl.word  = word;

  // Advance the program
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_START;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= (protocol_version > MAX_VERSION) ? PC_ERROR : PC_START;
    end else if (step) begin
      if (word.last) begin
        busy <= 1'b0;
      end
      pc <= taken ? word.target : pc + PC_W'(1);
      if (word.load_cnt) begin
        cnt <= reps;
      end else if (word.dec_cnt) begin
        cnt <= cnt - REP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/dsc_datapath.sv
// ----------------------------------------------------------------------------
// dsc_datapath
// Holds the request operands and builds each action into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dsc_pkg::dsc_ctrl_t        ctrl,
  input  wire logic [dsc_pkg::NUM_W-1:0] input_number,
  input  wire logic                      polarization,
  input  wire logic                      band_select,
  output      logic                      room,
  dsc_res_if.source                      res
);
  import dsc_pkg::*;

  logic [NUM_W-1:0]  num;
  logic              pol;
  logic              band;
  logic [BYTE_W-1:0] value;
  logic [3:0]        nibble;
  logic              is_msg;

  // Latch operands on a request transfer
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      num  <= input_number;
      pol  <= polarization;
      band <= band_select;
    end
  end

  // Select the action value
  always_comb begin
    case (ctrl.word.val_sel)
      VAL_POL:    value = {7'd0, pol};
      VAL_SHORT:  value = SHORT_WAIT_MS;
      VAL_REPEAT: value = REPEAT_WAIT_MS;
      VAL_BURST:  value = {7'd0, num[0]};
      VAL_BAND:   value = {7'd0, band};
      default:    value = '0;
    endcase
  end

  assign nibble = ctrl.word.cmd_unc ? num[5:2] : {num[1:0], pol, band};
  assign is_msg = (ctrl.word.act == ACT_MSG);
  assign room   = !res.valid || res.ready;

  // Load the output register, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctrl.step) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      res.action         <= ctrl.word.act;
      res.action_value   <= value;
      res.frame_byte     <= is_msg ? (ctrl.word.frame_rep ? FRAME_REPEAT : FRAME_FIRST) : '0;
      res.device_address <= is_msg ? SWITCH_ADDR : '0;
      res.command_byte   <= is_msg ? (ctrl.word.cmd_unc ? CMD_UNCOMMITTED : CMD_COMMITTED)
                                   : '0;
      res.data_byte      <= is_msg ? {DATA_HIGH, nibble} : '0;
      res.message_length <= is_msg ? MSG_LEN : '0;
      res.last_action    <= ctrl.word.last;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dsc_checker.sv
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks on the switch sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         res_valid,
  input wire logic                         res_ready,
  input wire logic [dsc_pkg::ACT_W-1:0]    action,
  input wire logic [dsc_pkg::BYTE_W-1:0]   action_value,
  input wire logic [dsc_pkg::BYTE_W-1:0]   frame_byte,
  input wire logic [dsc_pkg::BYTE_W-1:0]   device_address,
  input wire logic [dsc_pkg::BYTE_W-1:0]   command_byte,
  input wire logic [dsc_pkg::LEN_W-1:0]    message_length,
  input wire logic                         last_action
);
  import dsc_pkg::*;

  // A request transfer starts a sequence, so no second one follows at once
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a sequence was starting");

  // A stalled action holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(action) && $stable(action_value)
                               && $stable(last_action))
    else $error("stalled action changed");

  // Messages carry the switch address, length and a committed or uncommitted command
  a_msg: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == ACT_MSG |-> device_address == SWITCH_ADDR &&
      message_length == MSG_LEN && (command_byte == CMD_COMMITTED ||
      command_byte == CMD_UNCOMMITTED))
    else $error("malformed switch message");

  // Non-message actions carry no message bytes
  a_no_msg: assert property (@(posedge clk) disable iff (rst)
    res_valid && action != ACT_MSG |-> frame_byte == '0 && message_length == '0)
    else $error("message bytes on a non-message action");

  // An error ends the request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == ACT_ERROR |-> last_action)
    else $error("error action not marked last");

endmodule

bind diseqc_switch_command_sequencer dsc_checker u_dsc_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .action         (res.action),
  .action_value   (res.action_value),
  .frame_byte     (res.frame_byte),
  .device_address (res.device_address),
  .command_byte   (res.command_byte),
  .message_length (res.message_length),
  .last_action    (res.last_action)
);

`default_nettype wire
